[rtl/tdpw_pkg.sv]
`timescale 1ns / 1ps
package tdpw_pkg;

	localparam int NUM_WORKERS      = 8;
	localparam int QUEUE_DEPTH_LOG2 = 4;

	localparam int QDEPTH  = 1 << QUEUE_DEPTH_LOG2;
	localparam int WIDX_W  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int CNT_W   = $clog2(NUM_WORKERS + 1);
	localparam int PTR_W   = QUEUE_DEPTH_LOG2 + 1;
	localparam int ADDR_W  = WIDX_W + QUEUE_DEPTH_LOG2;
	localparam int MEM_DEPTH = NUM_WORKERS * QDEPTH;

	// payload widths
	localparam int TASK_W   = 64;
	localparam int WORKER_W = 3;
	localparam int OCC_W    = 5;
	localparam int ACTIVE_W = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	typedef enum logic {
		REQ_ADD  = 1'b0,
		REQ_TAKE = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY = 8'd0,
		CFG_ACTIVE = 8'd1
	} cfg_reg_t;

	typedef enum logic {
		POL_RR = 1'b0,
		POL_LL = 1'b1
	} policy_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_FINISH
	} state_t;

	// least-load token walking the row of cells
	typedef struct packed {
		logic              vld;
		logic [PTR_W-1:0]  best;
		logic [WIDX_W-1:0] idx;
	} scan_tok_t;

	// per-cell queue commands
	typedef struct packed {
		logic push;
		logic pop;
	} cell_cmd_t;

endpackage

[rtl/tdpw_req_if.sv]
`timescale 1ns / 1ps
interface tdpw_req_if import tdpw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [TASK_W-1:0]   task_word;
	logic [WORKER_W-1:0] worker_index;

	modport source (output valid, req_type, task_word, worker_index, input ready);
	modport sink (input valid, req_type, task_word, worker_index, output ready);
endinterface

[rtl/tdpw_res_if.sv]
`timescale 1ns / 1ps
interface tdpw_res_if import tdpw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [WORKER_W-1:0] served_worker;
	logic [TASK_W-1:0]   task_out;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, status, served_worker, task_out, occupancy, input ready);
	modport sink (input valid, status, served_worker, task_out, occupancy, output ready);
endinterface

[rtl/tdpw_cfg_if.sv]
`timescale 1ns / 1ps
interface tdpw_cfg_if import tdpw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/tdpw_cell.sv]
`timescale 1ns / 1ps
module tdpw_cell import tdpw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WIDX_W-1:0] cell_id,
	input  logic [CNT_W-1:0]  n_act,
	input  cell_cmd_t         cmd,
	input  scan_tok_t         tok_in,
	output scan_tok_t         tok_out,
	output logic [PTR_W-1:0]  wp,
	output logic [PTR_W-1:0]  rp,
	output logic [PTR_W-1:0]  occ
);

	logic [PTR_W-1:0] wp_q, rp_q;
	scan_tok_t        tok_q;
	scan_tok_t        tok_nx;
	logic             active;

	assign occ    = wp_q - rp_q;
	assign active = CNT_W'(cell_id) < n_act;

	always_comb begin
		tok_nx = tok_in;
		// strict less keeps the lowest index on ties
		if (tok_in.vld && active && (occ < tok_in.best)) begin
			tok_nx.best = occ;
			tok_nx.idx  = cell_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			tok_q <= '0;
		end else begin
			if (cmd.push) wp_q <= wp_q + PTR_W'(1);
			if (cmd.pop)  rp_q <= rp_q + PTR_W'(1);
			tok_q <= tok_nx;
		end
	end

	assign tok_out = tok_q;
	assign wp      = wp_q;
	assign rp      = rp_q;

endmodule

[rtl/task_dispatcher_per_worker_queues.sv]
`timescale 1ns / 1ps
// round robin adds and takes pass idle, decide and finish; least-loaded adds
// also pass the scan state while the token walks the worker cells
// a new request is accepted only in idle, after the last result leaves finish
// reset: all queues empty, round robin with next worker 0, 8 workers active;
// descriptor store is not cleared
module task_dispatcher_per_worker_queues import tdpw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tdpw_req_if.sink  req,
	tdpw_res_if.source res,
	tdpw_cfg_if.sink  cfg
);

	state_t state_q, state_d;

	logic                policy_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [WIDX_W-1:0]   rr_q;

	logic                req_type_q;
	logic [TASK_W-1:0]   task_q;
	logic [WIDX_W-1:0]   w_q;
	logic [WORKER_W-1:0] srv_q;
	logic                in_pool_q;

	logic [1:0]          res_status_q;
	logic [OCC_W-1:0]    res_occ_q;
	logic                res_take_q;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [WORKER_W-1:0] out_worker_q;
	logic [TASK_W-1:0]   out_task_q;
	logic [OCC_W-1:0]    out_occ_q;

	logic [TASK_W-1:0]   mem [MEM_DEPTH];
	logic [TASK_W-1:0]   rdata_q;

	scan_tok_t           tok [NUM_WORKERS+1];
	cell_cmd_t           cmd [NUM_WORKERS];
	logic [PTR_W-1:0]    cell_wp [NUM_WORKERS];
	logic [PTR_W-1:0]    cell_rp [NUM_WORKERS];
	logic [PTR_W-1:0]    cell_occ [NUM_WORKERS];

	logic [CNT_W-1:0]    n_act, rr_inc, rr_nx;
	logic                accept, out_free, push_en, pop_en, load_out;
	logic [PTR_W-1:0]    sel_occ, sel_wp, sel_rp;
	logic [1:0]          dec_status;
	logic [OCC_W-1:0]    dec_occ;
	logic                in_pool;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || res.ready;
	assign in_pool  = 32'(req.worker_index) < NUM_WORKERS;

	// effective active count, clamped to 1..NUM_WORKERS
	always_comb begin
		if (active_q == '0)
			n_act = CNT_W'(1);
		else if (32'(active_q) > NUM_WORKERS)
			n_act = CNT_W'(NUM_WORKERS);
		else
			n_act = CNT_W'(active_q);
		rr_inc = CNT_W'(rr_q) + CNT_W'(1);
		rr_nx  = (rr_inc >= n_act) ? '0 : rr_inc;
	end

	// scan token enters cell 0 at the accept edge
	assign tok[0] = '{vld: accept && (req.req_type == REQ_ADD) && (policy_q == POL_LL),
		best: '1, idx: '0};

	for (genvar i = 0; i < NUM_WORKERS; i++) begin : g_cell
		assign cmd[i].push = push_en && (w_q == WIDX_W'(i));
		assign cmd[i].pop  = pop_en && (w_q == WIDX_W'(i));
		tdpw_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (WIDX_W'(i)),
			.n_act   (n_act),
			.cmd     (cmd[i]),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.wp      (cell_wp[i]),
			.rp      (cell_rp[i]),
			.occ     (cell_occ[i])
		);
	end

	assign sel_occ = in_pool_q ? cell_occ[w_q] : '0;
	assign sel_wp  = cell_wp[w_q];
	assign sel_rp  = cell_rp[w_q];

	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		push_en    = 1'b0;
		pop_en     = 1'b0;
		load_out   = 1'b0;
		dec_status = STAT_OK;
		dec_occ    = OCC_W'(sel_occ);
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.req_type == REQ_ADD && policy_q == POL_LL)
						state_d = S_SCAN;
					else
						state_d = S_DECIDE;
				end
			end
			S_SCAN: begin
				if (tok[NUM_WORKERS].vld) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_FINISH;
				if (req_type_q == REQ_ADD) begin
					if (32'(sel_occ) >= QDEPTH) begin
						dec_status = STAT_FULL;
					end else begin
						push_en = 1'b1;
						dec_occ = OCC_W'(sel_occ + PTR_W'(1));
					end
				end else begin
					if (sel_occ == '0) begin
						dec_status = STAT_EMPTY;
						dec_occ    = '0;
					end else begin
						pop_en  = 1'b1;
						dec_occ = OCC_W'(sel_occ - PTR_W'(1));
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= POL_RR;
			active_q    <= ACTIVE_W'(8);
			rr_q        <= WIDX_W'(NUM_WORKERS - 1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_POLICY: policy_q <= cfg.data[0];
					CFG_ACTIVE: active_q <= cfg.data[ACTIVE_W-1:0];
					default: ;
				endcase
			end
			if (accept && req.req_type == REQ_ADD && policy_q == POL_RR)
				rr_q <= WIDX_W'(rr_nx);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			task_q     <= req.task_word;
			if (req.req_type == REQ_TAKE) begin
				w_q       <= WIDX_W'(req.worker_index);
				srv_q     <= req.worker_index;
				in_pool_q <= in_pool;
			end else begin
				w_q       <= WIDX_W'(rr_nx);
				srv_q     <= WORKER_W'(rr_nx);
				in_pool_q <= 1'b1;
			end
		end
		if (state_q == S_SCAN && tok[NUM_WORKERS].vld) begin
			w_q   <= tok[NUM_WORKERS].idx;
			srv_q <= WORKER_W'(tok[NUM_WORKERS].idx);
		end
		if (state_q == S_DECIDE) begin
			res_status_q <= dec_status;
			res_occ_q    <= dec_occ;
			res_take_q   <= pop_en;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_worker_q <= srv_q;
			out_task_q   <= res_take_q ? rdata_q : '0;
			out_occ_q    <= res_occ_q;
		end
	end

	// descriptor store
	always_ff @(posedge clk) begin
		if (push_en)
			mem[{w_q, sel_wp[QUEUE_DEPTH_LOG2-1:0]}] <= task_q;
		if (pop_en)
			rdata_q <= mem[{w_q, sel_rp[QUEUE_DEPTH_LOG2-1:0]}];
	end

	assign cfg.ready         = 1'b1;
	assign res.valid         = out_valid_q;
	assign res.status        = out_status_q;
	assign res.served_worker = out_worker_q;
	assign res.task_out      = out_task_q;
	assign res.occupancy     = out_occ_q;

endmodule
